// File: design/krs_pkg.sv
`default_nettype none

package krs_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;
    localparam int TAG_BITS = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int RND_W    = $clog2(CAPACITY);
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic REG_DESCENDING = 1'b0;

    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_rec;

    typedef struct packed {
        logic shift;
        logic sort;
        logic phase;
        logic desc;
    } t_cell_ctl;

    function automatic logic goes_before(input t_rec a, input t_rec b, input logic desc);
        goes_before = desc ? (a.key > b.key) : (a.key < b.key);
    endfunction

endpackage

`default_nettype wire

// File: design/krs_cell.sv
`default_nettype none

module krs_cell
    import krs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_odd,
    input  wire t_rec      i_up,
    input  wire t_rec      i_dn,
    input  wire logic      i_swap_dn,
    output t_rec           o_rec,
    output logic           o_swap_up
);

    t_rec r_rec;
    t_rec n_rec;
    logic w_lower;

    // pair (k, k+1) is compared by its lower member; strict compare keeps ties in order
    assign w_lower   = i_ctl.sort && (i_odd == i_ctl.phase);
    assign o_swap_up = w_lower && r_rec.valid && i_up.valid
                       && goes_before(i_up, r_rec, i_ctl.desc);
    assign o_rec     = r_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.shift) begin
            n_rec = i_up;
        end else if (o_swap_up) begin
            n_rec = i_up;
        end else if (i_swap_dn) begin
            n_rec = i_dn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec.valid <= 1'b0;
        end else begin
            r_rec <= n_rec;
        end
    end

endmodule

`default_nettype wire

// File: design/keyed_record_sorter_unit.sv
// Stable key sorter for sets of up to CAPACITY records. Records stream in at one per
// cycle into a row of cells (o_ready is high while the block collects a set); a record
// arriving with the store full is dropped and the whole set is flagged with o_overflow.
// The transfer carrying i_last_in closes the set and samples the descending register.
// The row then runs CAPACITY rounds of odd-even transposition between neighboring cells,
// after which records shift down to the head cell and leave at up to one per cycle as
// i_ready allows, ties in arrival order, o_last_out on the final one. No new set is
// accepted from the last record until the final result transfer.
`default_nettype none

module keyed_record_sorter_unit
    import krs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [KEY_BITS-1:0] i_key,
    input  wire logic [TAG_BITS-1:0] i_tag,
    input  wire logic                i_last_in,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [KEY_BITS-1:0]      o_sorted_key,
    output logic [TAG_BITS-1:0]      o_sorted_tag,
    output logic                     o_last_out,
    output logic                     o_overflow,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SORT = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [RND_W-1:0] r_round, n_round;
    logic             r_drop, n_drop;
    logic             r_desc, n_desc;
    logic             r_desc_run, n_desc_run;

    t_rec      w_rec  [CAPACITY];
    logic      w_swap [CAPACITY];
    t_rec      w_in_rec;
    t_cell_ctl w_ctl;
    logic      w_in_xfer;
    logic      w_out_xfer;
    logic      w_full;
    logic      w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DESCENDING);
    assign prdata   = (paddr[2] == REG_DESCENDING) ? APB_DW'(r_desc) : '0;

    assign o_ready      = (r_state == ST_LOAD);
    assign w_in_xfer    = i_valid && o_ready;
    assign w_full       = (r_count == CNT_W'(CAPACITY));
    assign o_valid      = (r_state == ST_EMIT) && w_rec[0].valid;
    assign w_out_xfer   = o_valid && i_ready;
    assign o_sorted_key = w_rec[0].key;
    assign o_sorted_tag = w_rec[0].tag;
    assign o_last_out   = (r_count == CNT_W'(1));
    assign o_overflow   = r_drop;

    assign w_in_rec.valid = (r_state == ST_LOAD);
    assign w_in_rec.key   = i_key;
    assign w_in_rec.tag   = i_tag;

    assign w_ctl.shift = ((r_state == ST_LOAD) && w_in_xfer && !w_full)
                         || ((r_state == ST_EMIT) && (!w_rec[0].valid || i_ready));
    assign w_ctl.sort  = (r_state == ST_SORT);
    assign w_ctl.phase = r_round[0];
    assign w_ctl.desc  = r_desc_run;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_rec w_up;
        t_rec w_dn;
        logic w_sdn;
        if (k == CAPACITY - 1) begin : g_top
            assign w_up = w_in_rec;
        end else begin : g_mid
            assign w_up = w_rec[k+1];
        end
        if (k == 0) begin : g_head
            assign w_dn  = '0;
            assign w_sdn = 1'b0;
        end else begin : g_body
            assign w_dn  = w_rec[k-1];
            assign w_sdn = w_swap[k-1];
        end
        krs_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_odd     (1'(k % 2)),
            .i_up      (w_up),
            .i_dn      (w_dn),
            .i_swap_dn (w_sdn),
            .o_rec     (w_rec[k]),
            .o_swap_up (w_swap[k])
        );
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_round    = r_round;
        n_drop     = r_drop;
        n_desc     = r_desc;
        n_desc_run = r_desc_run;
        if (w_cfg_wr) begin
            n_desc = pwdata[0];
        end
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_xfer) begin
                    if (w_full) begin
                        n_drop = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_last_in) begin
                        n_desc_run = r_desc;
                        n_round    = '0;
                        n_state    = ST_SORT;
                    end
                end
            end
            ST_SORT: begin
                n_round = r_round + RND_W'(1);
                if (r_round == RND_W'(CAPACITY - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_xfer) begin
                    n_count = r_count - CNT_W'(1);
                    if (o_last_out) begin
                        n_drop  = 1'b0;
                        n_state = ST_LOAD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_count    <= '0;
            r_round    <= '0;
            r_drop     <= 1'b0;
            r_desc     <= 1'b0;
            r_desc_run <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_round    <= n_round;
            r_drop     <= n_drop;
            r_desc     <= n_desc;
            r_desc_run <= n_desc_run;
        end
    end

    a_valid_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_count != '0))
        else $error("result offered with empty record count");

    a_top_no_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_swap[CAPACITY-1])
        else $error("top cell swapped with the input side");

    a_head_empty_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_LOAD) && w_rec[0].valid) |-> w_full)
        else $error("head cell filled before the row is full");

    a_drained_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && o_last_out) |=> ((r_state == ST_LOAD) && !w_rec[0].valid
                                        && (r_count == '0) && !r_drop))
        else $error("row not drained after final transfer");

endmodule

`default_nettype wire

// File: sim/keyed_record_sorter_unit_chk.sv
`timescale 1ns / 100ps

module keyed_record_sorter_unit_chk
    import krs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rec_valid,
    input  logic                i_rec_ready,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [TAG_BITS-1:0] i_tag,
    input  logic                i_last_in,
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  logic [KEY_BITS-1:0] i_sorted_key,
    input  logic [TAG_BITS-1:0] i_sorted_tag,
    input  logic                i_last_out,
    input  logic                i_overflow,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    input  logic [APB_DW-1:0]   prdata,
    input  logic                pready,
    output int                  o_fail_cnt,
    output int                  o_pending,
    output int                  o_rec_cnt,
    output int                  o_set_cnt,
    output int                  o_result_cnt,
    output int                  o_desc_set_cnt,
    output int                  o_ovf_set_cnt
);

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } keyed_rec_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
        logic                last;
        logic                ovf;
    } ranked_rec_t;

    keyed_rec_t  open_set_q[$];
    ranked_rec_t ranked_q[$];
    logic        set_dropped = 1'b0;
    logic        desc_order  = 1'b0;
    int          fail_cnt    = 0;
    int          rec_cnt     = 0;
    int          set_cnt     = 0;
    int          result_cnt  = 0;
    int          desc_set_cnt = 0;
    int          ovf_set_cnt = 0;

    assign o_fail_cnt     = fail_cnt;
    assign o_pending      = ranked_q.size();
    assign o_rec_cnt      = rec_cnt;
    assign o_set_cnt      = set_cnt;
    assign o_result_cnt   = result_cnt;
    assign o_desc_set_cnt = desc_set_cnt;
    assign o_ovf_set_cnt  = ovf_set_cnt;

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
        fail_cnt++;
    endtask

    // stable insertion by key; equal keys stay in arrival order
    function automatic void rank_open_set();
        keyed_rec_t  ordered[$];
        keyed_rec_t  cur;
        ranked_rec_t r;
        int          j;
        ordered = {};
        foreach (open_set_q[i]) begin
            cur = open_set_q[i];
            j = ordered.size();
            ordered.push_back(cur);
            while (j > 0 && (desc_order ? (cur.key > ordered[j-1].key)
                                        : (cur.key < ordered[j-1].key))) begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = cur;
        end
        foreach (ordered[i]) begin
            r.key  = ordered[i].key;
            r.tag  = ordered[i].tag;
            r.last = (i == ordered.size() - 1);
            r.ovf  = set_dropped;
            ranked_q.push_back(r);
        end
        set_cnt++;
        if (desc_order)
            desc_set_cnt++;
        if (set_dropped)
            ovf_set_cnt++;
        open_set_q  = {};
        set_dropped = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        ranked_rec_t want;
        keyed_rec_t  rec;
        if (!i_rst_n) begin
            open_set_q  = {};
            ranked_q    = {};
            set_dropped = 1'b0;
            desc_order  = 1'b0;
        end else begin
            if (psel && penable && pready && paddr[APB_AW-1:2] == REG_DESCENDING) begin
                if (pwrite)
                    desc_order = pwdata[0];
                else if (prdata[0] !== desc_order)
                    report_mismatch("descending readback", desc_order, prdata[0]);
            end

            if (i_res_valid && i_res_ready) begin
                result_cnt++;
                if (ranked_q.size() == 0) begin
                    report_mismatch("result with nothing pending", '0,
                                    {i_sorted_key, i_sorted_tag});
                end else begin
                    want = ranked_q.pop_front();
                    if (i_sorted_key !== want.key)
                        report_mismatch("sorted_key", want.key, i_sorted_key);
                    if (i_sorted_tag !== want.tag)
                        report_mismatch("sorted_tag", want.tag, i_sorted_tag);
                    if (i_last_out !== want.last)
                        report_mismatch("last_out", want.last, i_last_out);
                    if (i_overflow !== want.ovf)
                        report_mismatch("overflow", want.ovf, i_overflow);
                end
            end

            if (i_rec_valid && i_rec_ready) begin
                rec_cnt++;
                rec.key = i_key;
                rec.tag = i_tag;
                if (open_set_q.size() < CAPACITY)
                    open_set_q.push_back(rec);
                else
                    set_dropped = 1'b1;
                if (i_last_in)
                    rank_open_set();
            end
        end
    end

endmodule

// File: sim/keyed_record_sorter_unit_tb.sv
`timescale 1ns / 100ps

module keyed_record_sorter_unit_tb;

    import krs_pkg::*;

    localparam int                WATCHDOG_LIMIT = 4000;
    localparam int                DRAIN_CYCLES   = 2 * CAPACITY + 16;
    localparam int                PHASE_RECORDS  = 70;
    localparam logic [APB_AW-3:0] REG_SPARE      = 1'b1;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                i_valid   = 1'b0;
    logic [KEY_BITS-1:0] i_key     = '0;
    logic [TAG_BITS-1:0] i_tag     = '0;
    logic                i_last_in = 1'b0;
    logic                i_ready   = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [APB_AW-1:0]   paddr     = '0;
    logic [APB_DW-1:0]   pwdata    = '0;

    logic                o_ready;
    logic                o_valid;
    logic [KEY_BITS-1:0] o_sorted_key;
    logic [TAG_BITS-1:0] o_sorted_tag;
    logic                o_last_out;
    logic                o_overflow;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int fail_cnt;
    int pending;
    int rec_cnt;
    int set_cnt;
    int result_cnt;
    int desc_set_cnt;
    int ovf_set_cnt;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    keyed_record_sorter_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_key        (i_key),
        .i_tag        (i_tag),
        .i_last_in    (i_last_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sorted_key (o_sorted_key),
        .o_sorted_tag (o_sorted_tag),
        .o_last_out   (o_last_out),
        .o_overflow   (o_overflow),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    keyed_record_sorter_unit_chk u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rec_valid    (i_valid),
        .i_rec_ready    (o_ready),
        .i_key          (i_key),
        .i_tag          (i_tag),
        .i_last_in      (i_last_in),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_sorted_key   (o_sorted_key),
        .i_sorted_tag   (o_sorted_tag),
        .i_last_out     (o_last_out),
        .i_overflow     (o_overflow),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_fail_cnt     (fail_cnt),
        .o_pending      (pending),
        .o_rec_cnt      (rec_cnt),
        .o_set_cnt      (set_cnt),
        .o_result_cnt   (result_cnt),
        .o_desc_set_cnt (desc_set_cnt),
        .o_ovf_set_cnt  (ovf_set_cnt)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // no transfer on any port for too long means the block hung
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer", quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic set_idle_mode(input idle_mode_e mode);
        send_idle_pct = (mode == IDLE_SENDER)   ? 48 : (mode == IDLE_BOTH) ? 21 : 0;
        stall_pct     = (mode == IDLE_RECEIVER) ? 48 : (mode == IDLE_BOTH) ? 21 : 0;
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        logic [KEY_BITS-1:0] k;
        k = $urandom;
        case ($urandom_range(4))
            1: k = $urandom_range(7);
            2: k = $urandom_range(1) ? '1 : '0;
            3: k[KEY_BITS-1] = 1'b0;
            4: k = k >> $urandom_range(KEY_BITS - 1);
            default: ;
        endcase
        return k;
    endfunction

    task automatic send_rec(input logic [KEY_BITS-1:0] key, input logic [TAG_BITS-1:0] tag,
                            input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_key     <= key;
        i_tag     <= tag;
        i_last_in <= last;
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_rec(pick_key(), TAG_BITS'($urandom), i == n - 1);
    endtask

    task automatic wait_sorted_out();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_AW-3:0] idx,
                              input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [APB_DW-1:0] wdata;
        int                n;
        int                sent;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idle_mode(IDLE_NONE);

        // ascending from reset: single-record sets, then extremes, float bits and ties
        send_rec('0, '0, 1'b1);
        send_rec('1, '1, 1'b1);
        send_rec('1, 16'h0001, 1'b0);
        send_rec('0, '1, 1'b0);
        send_rec(32'h7f80_0000, 16'h0002, 1'b0);
        send_rec(32'h3f80_0000, 16'h0003, 1'b0);
        send_rec(32'h0000_0005, 16'haaaa, 1'b0);
        send_rec(32'h0000_0005, 16'h5555, 1'b0);
        send_rec(32'h0000_0005, '0, 1'b0);
        send_rec('0, 16'h0001, 1'b1);
        wait_sorted_out();

        apb_access(1'b0, REG_DESCENDING, '0);
        apb_access(1'b1, REG_DESCENDING, '1);
        apb_access(1'b0, REG_DESCENDING, '0);
        send_rec(32'h0000_0005, 16'h0011, 1'b0);
        send_rec('1, 16'h0012, 1'b0);
        send_rec(32'h0000_0005, 16'h0013, 1'b0);
        send_rec('0, 16'h0014, 1'b0);
        send_rec('1, 16'h0015, 1'b0);
        send_rec(32'h3f80_0000, 16'h0016, 1'b1);
        wait_sorted_out();

        // write to an unused index must leave the order alone
        apb_access(1'b1, REG_SPARE, '0);
        apb_access(1'b0, REG_SPARE, '0);
        apb_access(1'b0, REG_DESCENDING, '0);
        send_rec(32'h0000_0009, 16'h0021, 1'b0);
        send_rec(32'h0000_0009, 16'h0022, 1'b1);
        wait_sorted_out();

        // full store, then a set past capacity whose last three records are dropped
        set_idle_mode(IDLE_BOTH);
        send_set(CAPACITY);
        wait_sorted_out();
        wdata = $urandom;
        wdata[0] = 1'b0;
        apb_access(1'b1, REG_DESCENDING, wdata);
        send_set(CAPACITY + 3);
        wait_sorted_out();

        for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
            wdata = $urandom;
            wdata[0] = m[0];
            apb_access(1'b1, REG_DESCENDING, wdata);
            set_idle_mode(idle_mode_e'(m));
            sent = 0;
            while (sent < PHASE_RECORDS) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
                send_set(n);
                sent += n;
            end
            wait_sorted_out();
        end

        set_idle_mode(IDLE_NONE);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d records in %0d sets, %0d sorted results compared",
                 rec_cnt, set_cnt, result_cnt);
        $display("summary: %0d sets sorted descending, %0d sets dropped records",
                 desc_set_cnt, ovf_set_cnt);
        if (fail_cnt == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
